>>> hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Holds list sizing, operation and status codes, and the per-cell control.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);

    // fixed field widths of the stream payloads
    localparam int OP_W      = 4;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 5;
    localparam int ST_W      = 3;
    localparam int IDX_OUT_W = 5;
    localparam int COUNT_W   = 5;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // width wide enough to compare a position with the count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 4'd0,
        OP_INS_BACK  = 4'd1,
        OP_INS_AT    = 4'd2,
        OP_DEL_FRONT = 4'd3,
        OP_DEL_BACK  = 4'd4,
        OP_DEL_AT    = 4'd5,
        OP_DEL_VALUE = 4'd6,
        OP_READ_AT   = 4'd7,
        OP_FIND      = 4'd8,
        OP_CLEAR     = 4'd9
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_RANGE  = 3'd3,
        ST_ABSENT = 3'd4
    } status_t;

    // per-cell update: load new word, take from lower or upper neighbor
    typedef struct packed {
        logic load;
        logic take_lo;
        logic take_hi;
    } cell_ctl_t;

endpackage

>>> hw/rtl/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core: ordered list of words in a chain of cells
// Each request carries one list operation; each gives exactly one result.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries requests: operation, value and position in s_tdata.
//   m_ channel returns one result per request: status, data, index, found,
//   count and is_empty in m_tdata.
//   Every cell compares or shifts in the same cycle, so a request needs no
//   sequencing: the result shows on m_ the cycle after the request is taken.
//   Throughput is one request per cycle while results are taken; the output
//   register lets a new request in during the cycle its result leaves.
//   When m_tready is low with a result held, s_tready drops until it is
//   taken; the held result stays unchanged.
//   Reset (aresetn low, synchronous) empties the list and drops m_tvalid.
//   Slot contents are not cleared; only slots below the count are read.
// ----------------------------------------------------------------------------
module positional_list_engine_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] operation, [35:4] value, [40:36] position, [47:41] zero
    input  logic [ple_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] status, [34:3] data, [39:35] index, [40] found,
    // [45:41] count, [46] is_empty, [47] zero
    output logic [ple_pkg::M_TDATA_W-1:0] m_tdata
);
    import ple_pkg::*;

    logic                  accept;
    op_t                   op;
    logic [DATA_WIDTH-1:0] key;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      cnt_c;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TDATA_W-1:0]  m_tdata_next;

    logic [DATA_WIDTH-1:0] cell_q   [CAPACITY];
    logic [CAPACITY-1:0]   cell_match;
    cell_ctl_t             cell_ctl [CAPACITY];

    logic [CAPACITY-1:0]   hit;
    logic [IDX_W-1:0]      hit_idx;
    logic                  hit_any;

    logic                  ins_go;
    logic                  del_go;
    logic [CMP_W-1:0]      at;
    status_t               res_status;
    logic [DATA_WIDTH-1:0] res_data;
    logic [CMP_W-1:0]      res_index;
    logic                  res_found;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tdata[OP_W-1:0]);
    assign key      = DATA_WIDTH'(s_tdata[OP_W +: VAL_W]);
    assign pos_c    = CMP_W'(s_tdata[OP_W+VAL_W +: POS_W]);
    assign cnt_c    = CMP_W'(count_reg);

    // the cell chain; ends feed the insert word and the cell's own word
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] lo_w;
        logic [DATA_WIDTH-1:0] hi_w;
        if (g == 0) begin : g_lo_end
            assign lo_w = key;
        end else begin : g_lo
            assign lo_w = cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_hi_end
            assign hi_w = cell_q[g];
        end else begin : g_hi
            assign hi_w = cell_q[g+1];
        end
        ple_cell u_cell (
            .aclk     (aclk),
            .ctl      (cell_ctl[g]),
            .ins_data (key),
            .lo_data  (lo_w),
            .hi_data  (hi_w),
            .key      (key),
            .q        (cell_q[g]),
            .match    (cell_match[g])
        );
    end

    // first live slot that matches the key
    always_comb begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit[i] = cell_match[i] && (CMP_W'(i) < cnt_c);
        end
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_idx = IDX_W'(i);
                hit_any = 1'b1;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        ins_go     = 1'b0;
        del_go     = 1'b0;
        at         = '0;
        res_status = ST_OK;
        res_data   = '0;
        res_index  = '0;
        res_found  = 1'b0;
        case (op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                if (cnt_c == CMP_W'(CAPACITY)) begin
                    res_status = ST_FULL;
                end else if (op == OP_INS_AT && pos_c > cnt_c) begin
                    res_status = ST_RANGE;
                end else begin
                    ins_go     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (op == OP_INS_FRONT) begin
                        at = '0;
                    end else if (op == OP_INS_BACK) begin
                        at = cnt_c;
                    end else begin
                        at = pos_c;
                    end
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                if (count_reg == '0) begin
                    res_status = ST_EMPTY;
                end else if (op == OP_DEL_AT && pos_c >= cnt_c) begin
                    res_status = ST_RANGE;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    // dropping the last slot needs no shift
                    del_go     = (op != OP_DEL_BACK);
                    at         = (op == OP_DEL_FRONT) ? '0 : pos_c;
                end
            end
            OP_DEL_VALUE, OP_FIND: begin
                if (hit_any) begin
                    res_index = CMP_W'(hit_idx);
                    res_found = 1'b1;
                    if (op == OP_DEL_VALUE) begin
                        del_go     = 1'b1;
                        at         = CMP_W'(hit_idx);
                        count_next = count_reg - CNT_W'(1);
                    end
                end else begin
                    res_index  = cnt_c;
                    res_status = ST_ABSENT;
                end
            end
            OP_READ_AT: begin
                if (count_reg == '0) begin
                    res_status = ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    res_status = ST_RANGE;
                end else begin
                    res_data = cell_q[pos_c[IDX_W-1:0]];
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctl[i].load    = accept && ins_go && (CMP_W'(i) == at);
            cell_ctl[i].take_lo = accept && ins_go && (CMP_W'(i) > at);
            cell_ctl[i].take_hi = accept && del_go && (CMP_W'(i) >= at)
                                  && (i < CAPACITY - 1);
        end
    end

    assign m_tdata_next = {1'b0,
                           (count_next == '0),
                           COUNT_W'(count_next),
                           res_found,
                           IDX_OUT_W'(res_index),
                           VAL_W'(res_data),
                           res_status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without a request");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[46] == (m_tdata_reg[45:41] == '0)))
        else $error("is_empty disagrees with count");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[40]) |-> (m_tdata_reg[2:0] == ST_OK))
        else $error("found result with error status");
`endif

endmodule

>>> hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one slot of the list
// Holds one word, compares it with the broadcast key, and on command loads
// a new word or takes the word of its lower or upper neighbor.
// ----------------------------------------------------------------------------
module ple_cell (
    input  logic                           aclk,
    input  ple_pkg::cell_ctl_t             ctl,
    input  logic [ple_pkg::DATA_WIDTH-1:0] ins_data,
    input  logic [ple_pkg::DATA_WIDTH-1:0] lo_data,
    input  logic [ple_pkg::DATA_WIDTH-1:0] hi_data,
    input  logic [ple_pkg::DATA_WIDTH-1:0] key,
    output logic [ple_pkg::DATA_WIDTH-1:0] q,
    output logic                           match
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            data_reg <= ins_data;
        end else if (ctl.take_lo) begin
            data_reg <= lo_data;
        end else if (ctl.take_hi) begin
            data_reg <= hi_data;
        end
    end

    assign q     = data_reg;
    assign match = (data_reg == key);

endmodule
